>>> rtl/ecd_pkg.sv
// ecd_pkg: widths, constants, reciprocal multipliers and month tables for the
// epoch seconds to calendar date converter
// no dependencies
`default_nettype none

package ecd_pkg;

    // field widths
    localparam int SECS_W   = 32;
    localparam int EPOCH_W  = 22;
    localparam int YEAR_W   = 16;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int HOUR_W   = 5;
    localparam int MIN_W    = 6;
    localparam int SEC_W    = 6;
    localparam int WDAY_W   = 3;

    // internal widths
    localparam int DAYS_W   = 16;
    localparam int REM_W    = 17;
    localparam int MREM_W   = 12;
    localparam int JDN_W    = 23;
    localparam int CENT_W   = 7;
    localparam int A2_W     = 16;
    localparam int YR4_W    = 7;
    localparam int A3_W     = 9;
    localparam int N_W      = 4;
    localparam int RAWYR_W  = 14;
    localparam int Y2_W     = 7;
    localparam int WSUM_W   = 7;
    localparam int Q_W      = 4;

    // calendar constants
    localparam int SECS_PER_DAY  = 86400;
    localparam int SECS_PER_HOUR = 3600;
    localparam int SECS_PER_MIN  = 60;
    localparam int JDN_OFFSET    = 32044;
    localparam int DAYS_400Y     = 146097;
    localparam int DAYS_4Y       = 1461;
    localparam int YEAR_BIAS     = 4800;
    localparam int DAYS_PER_WEEK = 7;
    localparam int YEARS_PER_CENT = 100;
    localparam logic [EPOCH_W-1:0] EPOCH_RESET = EPOCH_W'(2451545);

    // seconds to days: drop 7 bits, then divide by 675 (86400 = 128 * 675)
    localparam int DAY_PRE  = 7;
    localparam int DAY_DIV  = 675;
    localparam int DAY_SH   = 35;
    localparam int DAY_MW   = 26;
    localparam logic [DAY_MW-1:0] DAY_MUL =
        DAY_MW'(((64'd1 << DAY_SH) + 64'(DAY_DIV) - 64'd1) / 64'(DAY_DIV));

    localparam int HOUR_SH  = 29;
    localparam int HOUR_MW  = 18;
    localparam logic [HOUR_MW-1:0] HOUR_MUL =
        HOUR_MW'(((64'd1 << HOUR_SH) + 64'(SECS_PER_HOUR) - 64'd1) / 64'(SECS_PER_HOUR));

    localparam int MIN_SH   = 18;
    localparam int MIN_MW   = 13;
    localparam logic [MIN_MW-1:0] MIN_MUL =
        MIN_MW'(((64'd1 << MIN_SH) + 64'(SECS_PER_MIN) - 64'd1) / 64'(SECS_PER_MIN));

    localparam int CENT_SH  = 43;
    localparam int CENT_MW  = 26;
    localparam logic [CENT_MW-1:0] CENT_MUL =
        CENT_MW'(((64'd1 << CENT_SH) + 64'(DAYS_400Y) - 64'd1) / 64'(DAYS_400Y));

    localparam int YR4_SH   = 29;
    localparam int YR4_MW   = 19;
    localparam logic [YR4_MW-1:0] YR4_MUL =
        YR4_MW'(((64'd1 << YR4_SH) + 64'(DAYS_4Y) - 64'd1) / 64'(DAYS_4Y));

    localparam int MSPAN    = 153;
    localparam int N_SH     = 19;
    localparam int N_MW     = 12;
    localparam logic [N_MW-1:0] N_MUL =
        N_MW'(((64'd1 << N_SH) + 64'(MSPAN) - 64'd1) / 64'(MSPAN));

    localparam int Y12_DIV  = 12;
    localparam int Y12_SH   = 11;
    localparam int Y12_MW   = 8;
    localparam logic [Y12_MW-1:0] Y12_MUL =
        Y12_MW'(((64'd1 << Y12_SH) + 64'(Y12_DIV) - 64'd1) / 64'(Y12_DIV));

    localparam int W7_SH    = 10;
    localparam int W7_MW    = 8;
    localparam logic [W7_MW-1:0] W7_MUL =
        W7_MW'(((64'd1 << W7_SH) + 64'(DAYS_PER_WEEK) - 64'd1) / 64'(DAYS_PER_WEEK));

    // pipeline depth
    localparam int DATE_LAT = 8;
    localparam int WD_LAT   = 4;
    localparam int PIPE_LAT = DATE_LAT + WD_LAT;

    // month index n counts from march
    localparam logic [N_W-1:0] N_JAN = N_W'(10);

    typedef struct packed {
        logic               valid_res;
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day_of_month;
        logic [HOUR_W-1:0]  hour;
        logic [MIN_W-1:0]   minute;
        logic [SEC_W-1:0]   second;
    } date_word_t;

    typedef struct packed {
        logic              known;
        logic [Y2_W-1:0]   y2;
        logic [WDAY_W-1:0] anchor;
        logic              leap_jf;
        logic [DAY_W-1:0]  day_of_month;
    } wd_word_t;

    // days before the first of month n, (153 n + 2) / 5
    function automatic logic [A3_W-1:0] month_start(input logic [N_W-1:0] n);
        logic [A3_W-1:0] d;
        unique case (n)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd31;
            4'd2:    d = 9'd61;
            4'd3:    d = 9'd92;
            4'd4:    d = 9'd122;
            4'd5:    d = 9'd153;
            4'd6:    d = 9'd184;
            4'd7:    d = 9'd214;
            4'd8:    d = 9'd245;
            4'd9:    d = 9'd275;
            4'd10:   d = 9'd306;
            4'd11:   d = 9'd337;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

    // weekday anchor of the month reached by index n
    function automatic logic [WDAY_W-1:0] month_anchor(input logic [N_W-1:0] n);
        logic [WDAY_W-1:0] w;
        unique case (n)
            4'd0:    w = 3'd2;
            4'd1:    w = 3'd5;
            4'd2:    w = 3'd0;
            4'd3:    w = 3'd3;
            4'd4:    w = 3'd5;
            4'd5:    w = 3'd1;
            4'd6:    w = 3'd4;
            4'd7:    w = 3'd6;
            4'd8:    w = 3'd2;
            4'd9:    w = 3'd4;
            4'd10:   w = 3'd6;
            4'd11:   w = 3'd2;
            default: w = 3'd0;
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

>>> rtl/ecd_weekday.sv
// ecd_weekday: four-stage weekday pipeline from two-digit year, month anchor
// and day of month; depends on ecd_pkg
`default_nettype none

module ecd_weekday (
    input  wire logic                   clk,
    input  wire ecd_pkg::wd_word_t      wd_in,
    output logic [ecd_pkg::WDAY_W-1:0]  weekday
);
    import ecd_pkg::*;

    wd_word_t              w1_word_reg;
    logic [Q_W-1:0]        w1_q12_reg;
    logic [Q_W-1:0]        w1_q12_next;
    logic [Y2_W+Y12_MW-1:0] y12_prod;

    logic [WSUM_W-1:0]     w2_sum_reg;
    logic [WSUM_W-1:0]     w2_sum_next;
    logic                  w2_known_reg;
    logic [Q_W-1:0]        r12;
    logic [Y2_W-1:0]       q12_x12;

    logic [WSUM_W-1:0]     w3_sum_reg;
    logic [Q_W-1:0]        w3_q7_reg;
    logic [Q_W-1:0]        w3_q7_next;
    logic                  w3_known_reg;
    logic [WSUM_W+W7_MW-1:0] w7_prod;

    logic [WDAY_W-1:0]     w4_wd_reg;
    logic [WDAY_W-1:0]     w4_wd_next;
    logic [WSUM_W-1:0]     q7_x7;

    // y2 / 12
    assign y12_prod    = (Y2_W+Y12_MW)'(wd_in.y2) * (Y2_W+Y12_MW)'(Y12_MUL);
    assign w1_q12_next = y12_prod[Y12_SH +: Q_W];

    // y2 / 12 + y2 % 12 + (y2 % 12) / 4 + anchor + leap fix + day
    always_comb
    begin
        q12_x12     = Y2_W'(w1_q12_reg) * Y2_W'(Y12_DIV);
        r12         = Q_W'(w1_word_reg.y2 - q12_x12);
        w2_sum_next = WSUM_W'(w1_q12_reg) + WSUM_W'(r12) + WSUM_W'(r12 >> 2)
                    + WSUM_W'(w1_word_reg.anchor)
                    + (w1_word_reg.leap_jf ? WSUM_W'(DAYS_PER_WEEK - 1) : '0)
                    + WSUM_W'(w1_word_reg.day_of_month);
    end

    // sum / 7
    assign w7_prod    = (WSUM_W+W7_MW)'(w2_sum_reg) * (WSUM_W+W7_MW)'(W7_MUL);
    assign w3_q7_next = w7_prod[W7_SH +: Q_W];

    always_comb
    begin
        q7_x7      = WSUM_W'(w3_q7_reg) * WSUM_W'(DAYS_PER_WEEK);
        w4_wd_next = w3_known_reg ? WDAY_W'(w3_sum_reg - q7_x7) : '0;
    end

    always_ff @(posedge clk)
    begin
        w1_word_reg  <= wd_in;
        w1_q12_reg   <= w1_q12_next;
        w2_sum_reg   <= w2_sum_next;
        w2_known_reg <= w1_word_reg.known;
        w3_sum_reg   <= w2_sum_reg;
        w3_q7_reg    <= w3_q7_next;
        w3_known_reg <= w2_known_reg;
        w4_wd_reg    <= w4_wd_next;
    end

    assign weekday = w4_wd_reg;

endmodule

`default_nettype wire

>>> rtl/epoch_seconds_to_calendar_date.sv
// epoch_seconds_to_calendar_date: pipelined conversion of seconds since a
// configurable epoch into date, time of day and weekday
// depends on ecd_pkg and ecd_weekday
//
//  channel  | ports                                         | handshake
//  ---------+-----------------------------------------------+-------------------
//  input    | seconds_since_epoch                           | start, busy
//  result   | valid_res year month day_of_month hour        | done (one cycle)
//           | minute second weekday                         |
//  config   | cfg_wdata (epoch julian day)                  | cfg_we
//
//  one word enters every cycle; busy stays low
//  result appears after 8 date stages that alternate reciprocal multiply and
//  remainder, then 4 weekday stages
//  rst_n clears the valid bits and loads the epoch 2000-01-01
//  results cannot be held off, so nothing in the pipeline ever stalls
`default_nettype none

module epoch_seconds_to_calendar_date (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [ecd_pkg::SECS_W-1:0]    seconds_since_epoch,
    input  wire logic                          cfg_we,
    input  wire logic [ecd_pkg::EPOCH_W-1:0]   cfg_wdata,
    output logic                               done,
    output logic                               valid_res,
    output logic [ecd_pkg::YEAR_W-1:0]         year,
    output logic [ecd_pkg::MONTH_W-1:0]        month,
    output logic [ecd_pkg::DAY_W-1:0]          day_of_month,
    output logic [ecd_pkg::HOUR_W-1:0]         hour,
    output logic [ecd_pkg::MIN_W-1:0]          minute,
    output logic [ecd_pkg::SEC_W-1:0]          second,
    output logic [ecd_pkg::WDAY_W-1:0]         weekday
);
    import ecd_pkg::*;

    localparam int DAYP_W = SECS_W - DAY_PRE + DAY_MW;
    localparam int HRP_W  = REM_W + HOUR_MW;
    localparam int CP_W   = JDN_W + 2 + CENT_MW;
    localparam int MNP_W  = MREM_W + MIN_MW;
    localparam int EP_W   = A2_W + 2 + YR4_MW;
    localparam int NX_W   = 11;
    localparam int NP_W   = NX_W + N_MW;

    logic [EPOCH_W-1:0]  epoch_reg;
    logic [PIPE_LAT-1:0] vld_reg;

    // stage 1
    logic [DAYP_W-1:0]   day_prod;
    logic [DAYS_W-1:0]   s1_days_reg;
    logic [REM_W-1:0]    s1_sec_lo_reg;
    logic                s1_nz_reg;
    // stage 2
    logic [DAYS_W+REM_W-1:0] day_secs;
    logic [REM_W-1:0]    s2_rem_next;
    logic [JDN_W-1:0]    s2_jdn_next;
    logic [REM_W-1:0]    s2_rem_reg;
    logic [JDN_W-1:0]    s2_jdn_reg;
    logic                s2_nz_reg;
    // stage 3
    logic [HRP_W-1:0]    hour_prod;
    logic [CP_W-1:0]     cent_prod;
    logic [HOUR_W-1:0]   s3_hour_reg;
    logic [CENT_W-1:0]   s3_cent_reg;
    logic [REM_W-1:0]    s3_rem_reg;
    logic [JDN_W-1:0]    s3_jdn_reg;
    logic                s3_nz_reg;
    // stage 4
    logic [REM_W-1:0]    hour_secs;
    logic [CENT_W+18-1:0] cent_days;
    logic [MREM_W-1:0]   s4_mrem_next;
    logic [A2_W-1:0]     s4_a2_next;
    logic [MREM_W-1:0]   s4_mrem_reg;
    logic [A2_W-1:0]     s4_a2_reg;
    logic [HOUR_W-1:0]   s4_hour_reg;
    logic [CENT_W-1:0]   s4_cent_reg;
    logic                s4_nz_reg;
    // stage 5
    logic [MNP_W-1:0]    min_prod;
    logic [EP_W-1:0]     yr4_prod;
    logic [MIN_W-1:0]    s5_min_reg;
    logic [YR4_W-1:0]    s5_yr4_reg;
    logic [MREM_W-1:0]   s5_mrem_reg;
    logic [A2_W-1:0]     s5_a2_reg;
    logic [HOUR_W-1:0]   s5_hour_reg;
    logic [CENT_W-1:0]   s5_cent_reg;
    logic                s5_nz_reg;
    // stage 6
    logic [MREM_W-1:0]   min_secs;
    logic [YR4_W+11-1:0] yr4_days;
    logic [SEC_W-1:0]    s6_sec_next;
    logic [A3_W-1:0]     s6_a3_next;
    logic [SEC_W-1:0]    s6_sec_reg;
    logic [A3_W-1:0]     s6_a3_reg;
    logic [MIN_W-1:0]    s6_min_reg;
    logic [YR4_W-1:0]    s6_yr4_reg;
    logic [HOUR_W-1:0]   s6_hour_reg;
    logic [CENT_W-1:0]   s6_cent_reg;
    logic                s6_nz_reg;
    // stage 7
    logic [NX_W-1:0]     n_x;
    logic [NP_W-1:0]     n_prod;
    logic [N_W-1:0]      s7_n_reg;
    logic [A3_W-1:0]     s7_a3_reg;
    logic [SEC_W-1:0]    s7_sec_reg;
    logic [MIN_W-1:0]    s7_min_reg;
    logic [YR4_W-1:0]    s7_yr4_reg;
    logic [HOUR_W-1:0]   s7_hour_reg;
    logic [CENT_W-1:0]   s7_cent_reg;
    logic                s7_nz_reg;
    // stage 8
    logic                jan_feb;
    logic [RAWYR_W-1:0]  raw_year;
    logic                before_zero;
    logic [Y2_W-1:0]     yy;
    logic [Y2_W-1:0]     y2;
    logic [DAY_W-1:0]    dom;
    date_word_t          s8_date_next;
    wd_word_t            s8_wd_next;
    date_word_t          s8_date_reg;
    wd_word_t            s8_wd_reg;
    // weekday alignment
    date_word_t          dly_reg [WD_LAT];
    logic [WDAY_W-1:0]   wd_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            epoch_reg <= EPOCH_RESET;
            vld_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                epoch_reg <= cfg_wdata;
            end
            vld_reg <= {vld_reg[PIPE_LAT-2:0], start && !busy};
        end
    end

    assign busy = 1'b0;

    // seconds / 86400
    assign day_prod = DAYP_W'(seconds_since_epoch[SECS_W-1:DAY_PRE]) * DAYP_W'(DAY_MUL);

    // time of day remainder and julian day
    always_comb
    begin
        day_secs    = (DAYS_W+REM_W)'(s1_days_reg) * (DAYS_W+REM_W)'(SECS_PER_DAY);
        s2_rem_next = s1_sec_lo_reg - day_secs[REM_W-1:0];
        s2_jdn_next = JDN_W'(s1_days_reg) + JDN_W'(JDN_OFFSET) + JDN_W'(epoch_reg);
    end

    // hour and 400-year cycle
    assign hour_prod = HRP_W'(s2_rem_reg) * HRP_W'(HOUR_MUL);
    assign cent_prod = CP_W'({s2_jdn_reg, 2'b11}) * CP_W'(CENT_MUL);

    always_comb
    begin
        hour_secs    = REM_W'(s3_hour_reg) * REM_W'(SECS_PER_HOUR);
        s4_mrem_next = MREM_W'(s3_rem_reg - hour_secs);
        cent_days    = (CENT_W+18)'(s3_cent_reg) * (CENT_W+18)'(DAYS_400Y);
        s4_a2_next   = A2_W'(s3_jdn_reg - JDN_W'(cent_days >> 2));
    end

    // minute and 4-year cycle
    assign min_prod = MNP_W'(s4_mrem_reg) * MNP_W'(MIN_MUL);
    assign yr4_prod = EP_W'({s4_a2_reg, 2'b11}) * EP_W'(YR4_MUL);

    always_comb
    begin
        min_secs    = MREM_W'(s5_min_reg) * MREM_W'(SECS_PER_MIN);
        s6_sec_next = SEC_W'(s5_mrem_reg - min_secs);
        yr4_days    = (YR4_W+11)'(s5_yr4_reg) * (YR4_W+11)'(DAYS_4Y);
        s6_a3_next  = A3_W'(s5_a2_reg - A2_W'(yr4_days >> 2));
    end

    // month index from march
    assign n_x    = NX_W'(s6_a3_reg) * NX_W'(5) + NX_W'(2);
    assign n_prod = NP_W'(n_x) * NP_W'(N_MUL);

    // year, month, day and weekday inputs
    always_comb
    begin
        jan_feb     = (s7_n_reg >= N_JAN);
        raw_year    = RAWYR_W'(s7_cent_reg) * RAWYR_W'(YEARS_PER_CENT)
                    + RAWYR_W'(s7_yr4_reg) + RAWYR_W'(jan_feb);
        before_zero = (raw_year < RAWYR_W'(YEAR_BIAS));
        yy          = Y2_W'(s7_yr4_reg) + Y2_W'(jan_feb);
        if (before_zero || yy == Y2_W'(YEARS_PER_CENT))
        begin
            y2 = '0;
        end
        else
        begin
            y2 = yy;
        end
        dom = DAY_W'(s7_a3_reg - month_start(s7_n_reg) + A3_W'(1));

        s8_date_next.valid_res    = s7_nz_reg;
        s8_date_next.year         = (before_zero || !s7_nz_reg) ? '0
                                  : YEAR_W'(raw_year - RAWYR_W'(YEAR_BIAS));
        s8_date_next.month        = !s7_nz_reg ? '0
                                  : jan_feb ? MONTH_W'(s7_n_reg - N_W'(9))
                                  : MONTH_W'(s7_n_reg + N_W'(3));
        s8_date_next.day_of_month = s7_nz_reg ? dom : '0;
        s8_date_next.hour         = s7_nz_reg ? s7_hour_reg : '0;
        s8_date_next.minute       = s7_nz_reg ? s7_min_reg : '0;
        s8_date_next.second       = s7_nz_reg ? s7_sec_reg : '0;

        s8_wd_next.known          = s7_nz_reg;
        s8_wd_next.y2             = y2;
        s8_wd_next.anchor         = month_anchor(s7_n_reg);
        s8_wd_next.leap_jf        = jan_feb && (y2[1:0] == 2'b00);
        s8_wd_next.day_of_month   = dom;
    end

    always_ff @(posedge clk)
    begin
        s1_days_reg   <= day_prod[DAY_SH +: DAYS_W];
        s1_sec_lo_reg <= seconds_since_epoch[REM_W-1:0];
        s1_nz_reg     <= (seconds_since_epoch != '0);

        s2_rem_reg    <= s2_rem_next;
        s2_jdn_reg    <= s2_jdn_next;
        s2_nz_reg     <= s1_nz_reg;

        s3_hour_reg   <= hour_prod[HOUR_SH +: HOUR_W];
        s3_cent_reg   <= cent_prod[CENT_SH +: CENT_W];
        s3_rem_reg    <= s2_rem_reg;
        s3_jdn_reg    <= s2_jdn_reg;
        s3_nz_reg     <= s2_nz_reg;

        s4_mrem_reg   <= s4_mrem_next;
        s4_a2_reg     <= s4_a2_next;
        s4_hour_reg   <= s3_hour_reg;
        s4_cent_reg   <= s3_cent_reg;
        s4_nz_reg     <= s3_nz_reg;

        s5_min_reg    <= min_prod[MIN_SH +: MIN_W];
        s5_yr4_reg    <= yr4_prod[YR4_SH +: YR4_W];
        s5_mrem_reg   <= s4_mrem_reg;
        s5_a2_reg     <= s4_a2_reg;
        s5_hour_reg   <= s4_hour_reg;
        s5_cent_reg   <= s4_cent_reg;
        s5_nz_reg     <= s4_nz_reg;

        s6_sec_reg    <= s6_sec_next;
        s6_a3_reg     <= s6_a3_next;
        s6_min_reg    <= s5_min_reg;
        s6_yr4_reg    <= s5_yr4_reg;
        s6_hour_reg   <= s5_hour_reg;
        s6_cent_reg   <= s5_cent_reg;
        s6_nz_reg     <= s5_nz_reg;

        s7_n_reg      <= n_prod[N_SH +: N_W];
        s7_a3_reg     <= s6_a3_reg;
        s7_sec_reg    <= s6_sec_reg;
        s7_min_reg    <= s6_min_reg;
        s7_yr4_reg    <= s6_yr4_reg;
        s7_hour_reg   <= s6_hour_reg;
        s7_cent_reg   <= s6_cent_reg;
        s7_nz_reg     <= s6_nz_reg;

        s8_date_reg   <= s8_date_next;
        s8_wd_reg     <= s8_wd_next;

        dly_reg[0]    <= s8_date_reg;
        for (int i = 1; i < WD_LAT; i++)
        begin
            dly_reg[i] <= dly_reg[i-1];
        end
    end

    ecd_weekday u_weekday (
        .clk     (clk),
        .wd_in   (s8_wd_reg),
        .weekday (wd_out)
    );

    assign done         = vld_reg[PIPE_LAT-1];
    assign valid_res    = dly_reg[WD_LAT-1].valid_res;
    assign year         = dly_reg[WD_LAT-1].year;
    assign month        = dly_reg[WD_LAT-1].month;
    assign day_of_month = dly_reg[WD_LAT-1].day_of_month;
    assign hour         = dly_reg[WD_LAT-1].hour;
    assign minute       = dly_reg[WD_LAT-1].minute;
    assign second       = dly_reg[WD_LAT-1].second;
    assign weekday      = wd_out;

endmodule

`default_nettype wire

>>> rtl/ecd_checker.sv
// ecd_checker: port-level assertions for the calendar date converter, bound
// to the top level; depends on ecd_pkg
`default_nettype none

module ecd_checker (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic                          busy,
    input  wire logic [ecd_pkg::SECS_W-1:0]    seconds_since_epoch,
    input  wire logic                          done,
    input  wire logic                          valid_res,
    input  wire logic [ecd_pkg::YEAR_W-1:0]    year,
    input  wire logic [ecd_pkg::MONTH_W-1:0]   month,
    input  wire logic [ecd_pkg::DAY_W-1:0]     day_of_month,
    input  wire logic [ecd_pkg::HOUR_W-1:0]    hour,
    input  wire logic [ecd_pkg::MIN_W-1:0]     minute,
    input  wire logic [ecd_pkg::SEC_W-1:0]     second,
    input  wire logic [ecd_pkg::WDAY_W-1:0]    weekday
);
    import ecd_pkg::*;

    // every taken word comes back after the fixed latency
    a_word_returns: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##PIPE_LAT done)
        else $error("taken word did not return");

    // no result without a word taken
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, PIPE_LAT))
        else $error("result without a taken word");

    // valid_res follows a nonzero input
    a_valid_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##PIPE_LAT
            (valid_res == ($past(seconds_since_epoch, PIPE_LAT) != '0)))
        else $error("valid_res does not match input");

    // unknown time gives all-zero fields
    a_unknown_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !valid_res) |-> (year == '0) && (month == '0)
            && (day_of_month == '0) && (hour == '0) && (minute == '0)
            && (second == '0) && (weekday == '0))
        else $error("unknown time with nonzero fields");

    // known time gives fields in range
    a_known_range: assert property (@(posedge clk) disable iff (!rst_n)
        (done && valid_res) |-> (month >= 4'd1) && (month <= 4'd12)
            && (day_of_month >= 5'd1) && (hour <= 5'd23) && (minute <= 6'd59)
            && (second <= 6'd59) && (weekday <= 3'd6))
        else $error("field out of range");

endmodule

bind epoch_seconds_to_calendar_date ecd_checker u_ecd_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .seconds_since_epoch (seconds_since_epoch),
    .done                (done),
    .valid_res           (valid_res),
    .year                (year),
    .month               (month),
    .day_of_month        (day_of_month),
    .hour                (hour),
    .minute              (minute),
    .second              (second),
    .weekday             (weekday)
);

`default_nettype wire
